// ===== rtl/core/ippt_pkg.sv =====
// Shared widths, character codes and helpers of the IPv6 prefix text parser.
// No dependencies; used by the channel interfaces and the parser top level.
package ippt_pkg;

    localparam int C_CH_W   = 8;
    localparam int C_HALF_W = 64;
    localparam int C_ADDR_W = 2 * C_HALF_W;
    localparam int C_LEN_W  = 8;

    localparam logic [C_CH_W-1:0] C_CH_AT    = 8'h40;  // '@'
    localparam logic [C_CH_W-1:0] C_CH_SLASH = 8'h2f;  // '/'
    localparam logic [C_CH_W-1:0] C_CH_COLON = 8'h3a;  // ':'

    localparam logic [9:0]          C_MAX_LEN      = 10'd128;
    localparam logic [C_HALF_W-1:0] C_PROJECT_MASK = 64'hffff_ffff_0000_0000;

    // Hex digit value in bits 3:0; bit 4 set when the character is no hex digit.
    function automatic logic [4:0] hex_value(input logic [C_CH_W-1:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/ippt_if.sv =====
// Valid/ready channels of the IPv6 prefix text parser: character in, prefix out.
// Depends on ippt_pkg for the payload widths.
interface ippt_char_if;
    import ippt_pkg::*;
    logic              valid;
    logic              ready;
    logic [C_CH_W-1:0] ch;
    logic              last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ippt_result_if;
    import ippt_pkg::*;
    logic                valid;
    logic                ready;
    logic                valid_res;
    logic [C_HALF_W-1:0] network_high;
    logic [C_HALF_W-1:0] network_low;
    logic [C_HALF_W-1:0] mask_high;
    logic [C_HALF_W-1:0] mask_low;
    logic [C_LEN_W-1:0]  prefix_length;
    logic                has_project;

    modport source (output valid, output valid_res, output network_high, output network_low,
                    output mask_high, output mask_low, output prefix_length,
                    output has_project, input ready);
    modport sink   (input valid, input valid_res, input network_high, input network_low,
                    input mask_high, input mask_low, input prefix_length,
                    input has_project, output ready);
endinterface

// ===== rtl/core/ipv6_prefix_text_parser.sv =====
// Streaming parser for [project@]ipv6/len text, one character per request.
// The final character of a string yields one result. A character is taken every
// cycle but for the stall below; the result of a string passes the input register,
// then the per-character update of the group file and the result build in one step
// into the output register. The only stall is a last character held while an
// untaken result still occupies the output register.
// Depends on ippt_pkg and the channel interfaces in ippt_if.sv.
module ipv6_prefix_text_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ippt_char_if.sink             i_char,
    ippt_result_if.source         o_result
);
    import ippt_pkg::*;

    typedef enum logic [1:0] {PH_LEAD, PH_ADDR, PH_MASK} t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [31:0]      accum;
        logic [3:0]       digits;
        logic [7:0][15:0] groups;
        logic [3:0]       groups_before;
        logic [3:0]       after;
        logic             seen_abbrev;
        logic             colon_pending;
        logic [31:0]      project;
        logic             project_seen;
        logic [9:0]       length;
        logic             failed;
    } t_state;

    localparam t_state C_STATE_RESET = '{phase: PH_LEAD, default: '0};

    logic              r_in_valid;
    logic [C_CH_W-1:0] r_ch;
    logic              r_last;
    t_state            r_st, n_st;

    logic                r_out_valid;
    logic                r_valid_res;
    logic [C_HALF_W-1:0] r_net_high, r_net_low, r_mask_high, r_mask_low;
    logic [C_LEN_W-1:0]  r_len;
    logic                r_has_project;

    logic                advance;
    logic [4:0]          hexd;
    logic                is_hex, fresh, do_addr, fail_now;
    logic [31:0]         acc;

    // close of the current group
    logic [7:0][15:0]    cg_groups;
    logic [3:0]          cg_before, cg_after;
    logic                cg_fail;
    logic [3:0]          gb_after_close;

    logic                res_ok;
    logic [7:0][15:0]    res_groups;
    logic [C_ADDR_W-1:0] res_mask;
    logic [C_ADDR_W-1:0] all_ones;

    assign advance      = r_in_valid && (!r_last || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || advance;

    assign hexd   = hex_value(r_ch);
    assign is_hex = !hexd[4];
    assign fresh  = (r_st.groups_before == 4'd0) && (r_st.after == 4'd0) && !r_st.seen_abbrev;

    // Leaving the lead phase on a non-hex character keeps only the low 16 bits.
    assign acc = (r_st.phase == PH_LEAD) ? {16'h0, r_st.accum[15:0]} : r_st.accum;

    always_comb begin
        cg_groups = r_st.groups;
        cg_before = r_st.groups_before;
        cg_after  = r_st.after;
        cg_fail   = 1'b0;
        if (r_st.seen_abbrev) begin
            cg_fail = ({1'b0, r_st.groups_before} + {1'b0, r_st.after}) >= 5'd7;
            // shift the groups after '::' up by one and insert at the bottom
            for (int j = 0; j < 7; j++) begin
                if (4'(j) < r_st.after) begin
                    cg_groups[j+1] = r_st.groups[j];
                end
            end
            cg_groups[0] = acc[15:0];
            cg_after     = r_st.after + 4'd1;
        end else begin
            cg_fail = r_st.groups_before >= 4'd8;
            cg_groups[3'd7 - r_st.groups_before[2:0]] = acc[15:0];
            cg_before = r_st.groups_before + 4'd1;
        end
        gb_after_close = (r_st.digits != 4'd0) ? cg_before : r_st.groups_before;
    end

    always_comb begin
        n_st     = r_st;
        fail_now = 1'b0;
        do_addr  = 1'b0;
        if (!r_st.failed) begin
            unique case (r_st.phase)
                PH_LEAD: begin
                    if (is_hex) begin
                        if (r_st.digits >= 4'd8) begin
                            fail_now = 1'b1;
                        end else begin
                            n_st.accum  = {r_st.accum[27:0], hexd[3:0]};
                            n_st.digits = r_st.digits + 4'd1;
                        end
                    end else if (r_ch == C_CH_AT) begin
                        if (r_st.digits == 4'd0) begin
                            fail_now = 1'b1;
                        end else begin
                            n_st.project      = r_st.accum;
                            n_st.project_seen = 1'b1;
                            n_st.accum        = '0;
                            n_st.digits       = '0;
                            n_st.phase        = PH_ADDR;
                        end
                    end else if (r_st.digits > 4'd4) begin
                        fail_now = 1'b1;
                    end else begin
                        n_st.accum = acc;
                        n_st.phase = PH_ADDR;
                        do_addr    = 1'b1;
                    end
                end
                PH_ADDR: do_addr = 1'b1;
                PH_MASK: begin
                    if (!is_hex || hexd[3:0] > 4'd9 || r_st.digits >= 4'd3) begin
                        fail_now = 1'b1;
                    end else begin
                        n_st.length = 10'({r_st.length, 3'b000} + {r_st.length, 1'b0}
                                          + {9'd0, hexd[3:0]});
                        n_st.digits = r_st.digits + 4'd1;
                    end
                end
                default: fail_now = 1'b1;
            endcase

            if (do_addr) begin
                if (is_hex) begin
                    if ((r_st.colon_pending && fresh) || r_st.digits >= 4'd4) begin
                        fail_now = 1'b1;
                    end else begin
                        n_st.accum         = {16'h0, acc[11:0], hexd[3:0]};
                        n_st.digits        = r_st.digits + 4'd1;
                        n_st.colon_pending = 1'b0;
                    end
                end else if (r_ch == C_CH_COLON) begin
                    if (r_st.digits != 4'd0) begin
                        fail_now           = cg_fail;
                        n_st.groups        = cg_groups;
                        n_st.groups_before = cg_before;
                        n_st.after         = cg_after;
                        n_st.digits        = '0;
                        n_st.accum         = '0;
                        n_st.colon_pending = 1'b1;
                    end else if (r_st.colon_pending) begin
                        if (r_st.seen_abbrev || r_st.groups_before >= 4'd8) begin
                            fail_now = 1'b1;
                        end else begin
                            n_st.seen_abbrev   = 1'b1;
                            n_st.colon_pending = 1'b0;
                        end
                    end else if (fresh) begin
                        n_st.colon_pending = 1'b1;
                    end else begin
                        fail_now = 1'b1;
                    end
                end else if (r_ch == C_CH_SLASH) begin
                    if (r_st.digits != 4'd0) begin
                        fail_now           = cg_fail;
                        n_st.groups        = cg_groups;
                        n_st.groups_before = cg_before;
                        n_st.after         = cg_after;
                        n_st.accum         = '0;
                    end else if (r_st.colon_pending) begin
                        fail_now = 1'b1;
                    end
                    if (!r_st.seen_abbrev && gb_after_close != 4'd8) begin
                        fail_now = 1'b1;
                    end
                    n_st.phase  = PH_MASK;
                    n_st.digits = '0;
                    n_st.length = '0;
                end else begin
                    fail_now = 1'b1;
                end
            end
        end
        n_st.failed = r_st.failed | fail_now;
    end

    // result of a string that ends with this character
    assign all_ones = '1;
    assign res_ok   = !n_st.failed && (n_st.phase == PH_MASK) && (n_st.digits != 4'd0)
                      && (n_st.length <= C_MAX_LEN);
    assign res_mask = ~(all_ones >> n_st.length[C_LEN_W-1:0]);

    always_comb begin
        res_groups = n_st.groups;
        if (n_st.project_seen) begin
            res_groups[2] = n_st.project[15:0];
            res_groups[3] = n_st.project[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= C_STATE_RESET;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_last) begin
                    r_st <= C_STATE_RESET;
                end else begin
                    r_st <= n_st;
                end
            end
        end
        if (i_char.ready) begin
            r_ch   <= i_char.ch;
            r_last <= i_char.last;
        end
        if (advance && r_last) begin
            r_valid_res   <= res_ok;
            r_net_high    <= res_ok ? res_groups[7:4] : '0;
            r_net_low     <= res_ok ? res_groups[3:0] : '0;
            r_mask_high   <= res_ok ? res_mask[C_ADDR_W-1:C_HALF_W] : '0;
            r_mask_low    <= res_ok ? (res_mask[C_HALF_W-1:0]
                                       | (n_st.project_seen ? C_PROJECT_MASK : '0)) : '0;
            r_len         <= res_ok ? n_st.length[C_LEN_W-1:0] : '0;
            r_has_project <= res_ok && n_st.project_seen;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.valid_res     = r_valid_res;
    assign o_result.network_high  = r_net_high;
    assign o_result.network_low   = r_net_low;
    assign o_result.mask_high     = r_mask_high;
    assign o_result.mask_low      = r_mask_low;
    assign o_result.prefix_length = r_len;
    assign o_result.has_project   = r_has_project;

endmodule
